// ===== hdl/stb_pkg.sv =====
// Package for the software timer bank: sizes, request modes and result codes.
// No dependencies; used by software_timer_bank, timer_bank_checker and testbench.
package stb_pkg;
	localparam int MaxTimersDefault = 16;
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_REG = 2'd1;
	localparam logic [1:0] MODE_UNREG_SLOT = 2'd2;
	localparam logic [1:0] MODE_UNREG_TAG = 2'd3;
	localparam logic [2:0] ST_REGISTERED = 3'd0;
	localparam logic [2:0] ST_REMOVED = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FIRED = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;
	localparam logic [2:0] ST_TICK_DONE = 3'd5;
endpackage

// ===== hdl/stb_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module stb_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/software_timer_bank.sv =====
// Top level of the software timer bank: sequencer, per-slot state, firing order.
// Depends on stb_pkg and stb_ram.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | mode slot timeout one_shot tag callback_id
//  output  | out_valid | out_stall | status slot_out tag_out callback_out last
//
// A request walks the firing order one position at a time through one shared
// compare unit; a tick reads and evaluates each live timer in turn, emits each fire
// and shifts the order for a one-shot removal, then sends the done result;
// a register shifts each live entry one position along the order.
// Reset (arst_n) empties the bank. The input stalls while a request is in work; the
// walk holds while a result waits in the output register.
module software_timer_bank import stb_pkg::*; #(
	parameter int MaxTimers = MaxTimersDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [3:0]  slot,
	input  logic [31:0] timeout,
	input  logic        one_shot,
	input  logic [31:0] tag,
	input  logic [31:0] callback_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  slot_out,
	output logic [31:0] tag_out,
	output logic [31:0] callback_out,
	output logic        last
);
	localparam int SW = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;
	localparam int CW = $clog2(MaxTimers + 1);
	localparam logic [CW-1:0] FullCount = CW'(MaxTimers);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_REG = 4'd1;
	localparam logic [3:0] S_SHIFT_UP = 4'd2;
	localparam logic [3:0] S_RD = 4'd3;
	localparam logic [3:0] S_WAIT = 4'd4;
	localparam logic [3:0] S_EVAL = 4'd5;
	localparam logic [3:0] S_SHIFT_DN = 4'd6;
	localparam logic [3:0] S_EMIT = 4'd7;

	logic [3:0] state_q;
	logic [1:0] mode_q;
	logic [3:0] slot_q;
	logic [31:0] timeout_q, tag_q, cb_q;
	logic one_shot_q;
	logic [MaxTimers-1:0] live_q, single_q;
	logic [CW-1:0] count_q, pos_q, sh_q;
	logic [SW-1:0] cur_q;
	logic [31:0] elapsed_q [MaxTimers];
	logic [SW-1:0] order_q [MaxTimers];
	logic cont_q; // after emitting a fire, continue the tick walk

	// shared stores for limit, tag and callback
	logic ram_we;
	logic [SW-1:0] ram_waddr, ram_raddr;
	logic [31:0] lim_rd, tag_rd, cb_rd;

	stb_ram #(.Width(32), .Depth(MaxTimers)) u_lim (.clk, .we(ram_we), .waddr(ram_waddr),
		.wdata(timeout_q), .raddr(ram_raddr), .rdata(lim_rd));
	stb_ram #(.Width(32), .Depth(MaxTimers)) u_tag (.clk, .we(ram_we), .waddr(ram_waddr),
		.wdata(tag_q), .raddr(ram_raddr), .rdata(tag_rd));
	stb_ram #(.Width(32), .Depth(MaxTimers)) u_cb (.clk, .we(ram_we), .waddr(ram_waddr),
		.wdata(cb_q), .raddr(ram_raddr), .rdata(cb_rd));

	// lowest free slot
	logic [SW-1:0] free_slot;
	logic any_free;
	always_comb begin
		free_slot = '0;
		any_free = 1'b0;
		for (int i = MaxTimers - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_slot = SW'(i);
				any_free = 1'b1;
			end
		end
	end

	logic [SW-1:0] pos_idx, sh_idx;
	assign pos_idx = pos_q[SW-1:0];
	assign sh_idx = sh_q[SW-1:0];
	logic [31:0] el_next;
	assign el_next = elapsed_q[cur_q] + 32'd1;

	assign ram_raddr = order_q[pos_idx];
	// drop the write when the bank is full
	assign ram_we = (state_q == S_REG) && any_free && (count_q < FullCount);
	assign ram_waddr = free_slot;
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			live_q <= '0;
			count_q <= '0;
			out_valid <= 1'b0;
			cont_q <= 1'b0;
			for (int i = 0; i < MaxTimers; i++) elapsed_q[i] <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != S_EMIT) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= mode;
						slot_q <= slot;
						timeout_q <= timeout;
						one_shot_q <= one_shot;
						tag_q <= tag;
						cb_q <= callback_id;
						pos_q <= '0;
						state_q <= (mode == MODE_REG) ? S_REG : S_RD;
					end
				end
				S_REG: begin
					if (!out_valid || !out_stall) begin
						if (!any_free || count_q >= FullCount) begin
							{status, slot_out} <= {ST_FULL, 4'd0};
							state_q <= S_EMIT;
							cont_q <= 1'b0;
						end else begin
							live_q[free_slot] <= 1'b1;
							single_q[free_slot] <= one_shot_q;
							elapsed_q[free_slot] <= '0;
							cur_q <= free_slot;
							sh_q <= count_q;
							state_q <= S_SHIFT_UP;
						end
					end
				end
				S_SHIFT_UP: begin
					// move the order down one position, then put the new slot first
					if (sh_q == '0) begin
						order_q[0] <= cur_q;
						count_q <= count_q + 1'b1;
						{status, slot_out} <= {ST_REGISTERED, 4'(cur_q)};
						cont_q <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						order_q[sh_idx] <= order_q[SW'(sh_q - 1'b1)];
						sh_q <= sh_q - 1'b1;
					end
				end
				S_RD: begin
					// hold while the previous result still waits
					if (!out_valid || !out_stall) begin
						if (pos_q >= count_q) begin
							if (mode_q == MODE_TICK) status <= ST_TICK_DONE;
							else status <= ST_NOT_FOUND;
							slot_out <= '0;
							cont_q <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							cur_q <= order_q[pos_idx];
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: state_q <= S_EVAL;
				S_EVAL: begin
					unique case (mode_q)
						MODE_TICK: begin
							if (el_next >= lim_rd) begin
								{status, slot_out} <= {ST_FIRED, 4'(cur_q)};
								tag_out <= tag_rd;
								callback_out <= cb_rd;
								cont_q <= 1'b1;
								if (single_q[cur_q]) begin
									sh_q <= pos_q;
									state_q <= S_SHIFT_DN;
								end else begin
									elapsed_q[cur_q] <= '0;
									pos_q <= pos_q + 1'b1;
									state_q <= S_EMIT;
								end
							end else begin
								elapsed_q[cur_q] <= el_next;
								pos_q <= pos_q + 1'b1;
								state_q <= S_RD;
							end
						end
						MODE_UNREG_SLOT, MODE_UNREG_TAG: begin
							if ((mode_q == MODE_UNREG_SLOT) ? (4'(cur_q) == slot_q)
									: (tag_rd == tag_q)) begin
								{status, slot_out} <= {ST_REMOVED, 4'(cur_q)};
								cont_q <= 1'b0;
								sh_q <= pos_q;
								state_q <= S_SHIFT_DN;
							end else begin
								pos_q <= pos_q + 1'b1;
								state_q <= S_RD;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_SHIFT_DN: begin
					// close the gap in the order, then free the slot
					if (sh_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
						live_q[cur_q] <= 1'b0;
						elapsed_q[cur_q] <= '0;
						state_q <= S_EMIT;
					end else begin
						order_q[sh_idx] <= order_q[SW'(sh_q + 1'b1)];
						sh_q <= sh_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						last <= !cont_q;
						if (!(status == ST_FIRED)) begin
							tag_out <= '0;
							callback_out <= '0;
						end
						state_q <= cont_q ? S_RD : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== verif/timer_bank_checker.sv =====
// Checker for the software timer bank: mirrors the timer list, predicts results, compares.
// Depends on stb_pkg; watches both channels of software_timer_bank.
module timer_bank_checker import stb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [3:0]  slot,
	input  logic [31:0] timeout,
	input  logic        one_shot,
	input  logic [31:0] tag,
	input  logic [31:0] callback_id,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [3:0]  slot_out,
	input  logic [31:0] tag_out,
	input  logic [31:0] callback_out,
	input  logic        last,
	output int          errors,
	output int          pending,
	output int          live_timers
);
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot;
		logic [31:0] tag;
		logic [31:0] cb;
		logic        last;
	} result_t;

	result_t     expected_results[$];
	logic        busy[16];
	logic [31:0] count[16];
	logic [31:0] period[16];
	logic        once[16];
	logic [31:0] owner[16];
	logic [31:0] action[16];
	logic [3:0]  order[16];
	int          n_live;

	assign pending = expected_results.size();
	assign live_timers = n_live;

	function automatic result_t make_result(logic [2:0] st, logic [3:0] sl,
			logic [31:0] tg, logic [31:0] cb, logic fin);
		result_t r;
		r.status = st;
		r.slot = sl;
		r.tag = tg;
		r.cb = cb;
		r.last = fin;
		return r;
	endfunction

	task automatic unlink(int pos);
		logic [3:0] s;
		s = order[pos];
		for (int i = pos; i + 1 < n_live; i++)
			order[i] = order[i + 1];
		n_live--;
		busy[s] = 1'b0;
		count[s] = '0;
	endtask

	task automatic predict_request(logic [1:0] md, logic [3:0] sl, logic [31:0] tmo,
			logic os, logic [31:0] tg, logic [31:0] cb);
		int free_slot;
		int pos;
		logic [3:0] s;
		free_slot = -1;
		pos = -1;
		case (md)
			MODE_REG: begin
				for (int i = 15; i >= 0; i--)
					if (!busy[i])
						free_slot = i;
				if (free_slot < 0) begin
					expected_results.push_back(make_result(ST_FULL, '0, '0, '0, 1'b1));
				end else begin
					busy[free_slot] = 1'b1;
					count[free_slot] = '0;
					period[free_slot] = tmo;
					once[free_slot] = os;
					owner[free_slot] = tg;
					action[free_slot] = cb;
					for (int i = n_live; i > 0; i--)
						order[i] = order[i - 1];
					order[0] = 4'(free_slot);
					n_live++;
					expected_results.push_back(make_result(ST_REGISTERED, 4'(free_slot),
						'0, '0, 1'b1));
				end
			end
			MODE_UNREG_SLOT: begin
				if (busy[sl])
					for (int i = 0; i < n_live; i++)
						if (order[i] == sl && pos < 0)
							pos = i;
				if (pos < 0) begin
					expected_results.push_back(make_result(ST_NOT_FOUND, '0, '0, '0, 1'b1));
				end else begin
					unlink(pos);
					expected_results.push_back(make_result(ST_REMOVED, sl, '0, '0, 1'b1));
				end
			end
			MODE_UNREG_TAG: begin
				for (int i = 0; i < n_live; i++)
					if (pos < 0 && owner[order[i]] == tg)
						pos = i;
				if (pos < 0) begin
					expected_results.push_back(make_result(ST_NOT_FOUND, '0, '0, '0, 1'b1));
				end else begin
					s = order[pos];
					unlink(pos);
					expected_results.push_back(make_result(ST_REMOVED, s, '0, '0, 1'b1));
				end
			end
			default: begin
				pos = 0;
				while (pos < n_live) begin
					s = order[pos];
					count[s] = count[s] + 1;
					if (count[s] >= period[s]) begin
						expected_results.push_back(make_result(ST_FIRED, s, owner[s],
							action[s], 1'b0));
						if (once[s]) begin
							unlink(pos);
							continue;
						end
						count[s] = '0;
					end
					pos++;
				end
				expected_results.push_back(make_result(ST_TICK_DONE, '0, '0, '0, 1'b1));
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			errors <= 0;
			n_live = 0;
			expected_results.delete();
			for (int i = 0; i < 16; i++) begin
				busy[i] = 1'b0;
				count[i] = '0;
			end
		end else begin
			if (out_valid && !out_stall) begin
				got = make_result(status, slot_out, tag_out, callback_out, last);
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (got != want) begin
						$display("%0t: mismatch expected st=%0d slot=%0d tag=%h cb=%h last=%b",
							$time, want.status, want.slot, want.tag, want.cb, want.last);
						$display("%0t:          actual st=%0d slot=%0d tag=%h cb=%h last=%b",
							$time, got.status, got.slot, got.tag, got.cb, got.last);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_request(mode, slot, timeout, one_shot, tag, callback_id);
		end
	end
endmodule

// ===== verif/testbench.sv =====
// Testbench top for software_timer_bank: clock, reset, request stimulus, verdict.
// Depends on stb_pkg, software_timer_bank and timer_bank_checker.
module testbench;
	import stb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [3:0]  slot;
	logic [31:0] timeout;
	logic        one_shot;
	logic [31:0] tag;
	logic [31:0] callback_id;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [3:0]  slot_out;
	logic [31:0] tag_out;
	logic [31:0] callback_out;
	logic        last;
	int          errors;
	int          pending;
	int          live_timers;
	int          cycles;
	int          hold_off;
	logic        calm;

	software_timer_bank u_top (.*);

	timer_bank_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stall, with one long hold-off while requests keep coming
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 19);
		end
	end

	// small tag pool so that tag matches happen
	function automatic logic [31:0] pick_tag();
		return ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(7));
	endfunction

	task automatic send(logic [1:0] md, logic [3:0] sl, logic [31:0] tmo, logic os,
			logic [31:0] tg, logic [31:0] cb);
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		slot <= sl;
		timeout <= tmo;
		one_shot <= os;
		tag <= tg;
		callback_id <= cb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_random();
		int r;
		logic [31:0] tmo;
		r = $urandom_range(99);
		tmo = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(5));
		if (r < 45)
			send(MODE_TICK, 4'($urandom), $urandom, 1'($urandom), $urandom, $urandom);
		else if (r < 75 || live_timers < 3)
			send(MODE_REG, 4'($urandom), tmo, 1'($urandom), pick_tag(), $urandom);
		else if (r < 88)
			send(MODE_UNREG_SLOT, 4'($urandom), $urandom, 1'($urandom), $urandom, $urandom);
		else
			send(MODE_UNREG_TAG, 4'($urandom), $urandom, 1'($urandom), pick_tag(), $urandom);
	endtask

	initial begin
		int wait_cycles;
		cycles = 0;
		hold_off = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		mode = MODE_TICK;
		slot = '0;
		timeout = '0;
		one_shot = 1'b0;
		tag = '0;
		callback_id = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, misses, zero and max timeouts, fill to full
		send(MODE_TICK, 4'd0, '0, 1'b0, '0, '0);
		send(MODE_UNREG_SLOT, 4'd15, '0, 1'b0, '0, '0);
		send(MODE_UNREG_TAG, 4'd0, '0, 1'b0, 32'hffff_ffff, '0);
		send(MODE_REG, 4'd0, 32'd0, 1'b0, 32'hffff_ffff, 32'hffff_ffff);
		send(MODE_REG, 4'd0, 32'hffff_ffff, 1'b1, 32'd0, 32'd0);
		send(MODE_REG, 4'd0, 32'd1, 1'b1, 32'h5555_aaaa, 32'haaaa_5555);
		send(MODE_REG, 4'd0, 32'd2, 1'b0, 32'd7, 32'd1);
		send(MODE_TICK, 4'd0, '0, 1'b0, '0, '0);
		send(MODE_TICK, 4'd0, '0, 1'b0, '0, '0);
		send(MODE_UNREG_TAG, 4'd0, '0, 1'b0, 32'hffff_ffff, '0);
		send(MODE_UNREG_SLOT, 4'd1, '0, 1'b0, '0, '0);
		// hold the output long enough that the block backs up into the input
		hold_off <= 300;
		for (int i = 0; i < 15; i++)
			send(MODE_REG, 4'd0, 32'($urandom_range(2)), 1'($urandom), 32'(i),
				$urandom);
		send(MODE_REG, 4'd0, 32'd3, 1'b0, 32'd99, 32'd99);
		send(MODE_TICK, 4'd0, '0, 1'b0, '0, '0);
		send(MODE_TICK, 4'd0, '0, 1'b0, '0, '0);

		for (int n = 0; n < 420; n++) begin
			calm <= (n >= 150 && n < 230);
			send_random();
		end
		calm <= 1'b0;
		in_valid <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
